@@ hw/rtl/smsr_pkg.sv @@
// shared types, constants and helpers for the stable merge sort block
package smsr_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int KEY_BITS    = 64;
    localparam int KEY_PORT_W  = 64;
    localparam int TAG_W       = 6;
    localparam int ADDR_W      = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int SUM_W       = CNT_W + 2;
    localparam int APB_ADDR_W  = 3;

    // register index codes
    localparam logic REG_COMPARE_MODE = 1'b0;

    // compare mode codes
    localparam logic MODE_SIGNED   = 1'b0;
    localparam logic MODE_UNSIGNED = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [KEY_BITS-1:0] key;
    } t_rec;

    // write request from the merge engine
    typedef struct packed {
        logic  en;
        logic  bank;
        t_addr addr;
        t_rec  data;
    } t_merge_wr;

    // read request from the merge engine
    typedef struct packed {
        logic  bank;
        t_addr a;
        t_addr b;
    } t_merge_rd;

    // status from the merge engine
    typedef struct packed {
        logic done;
        logic bank;
    } t_merge_stat;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SORT,
        S_EMIT_RD,
        S_EMIT_WR
    } t_top_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_SETUP,
        M_READ,
        M_PICK
    } t_merge_state;

    // unsigned-comparable image of a key
    function automatic logic [KEY_BITS-1:0] smsr_order_img(
        input logic [KEY_BITS-1:0] k,
        input logic                mode
    );
        logic [KEY_BITS-1:0] sign_flip;
        sign_flip = {1'b1, {(KEY_BITS-1){1'b0}}};
        return (mode == MODE_UNSIGNED) ? k : (k ^ sign_flip);
    endfunction

endpackage

@@ hw/rtl/smsr_ram.sv @@
// generic ram, one write port and two registered read ports
module smsr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ hw/rtl/smsr_merge.sv @@
// bottom-up stable merge sequencer, ping-pong between two banks
module smsr_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  smsr_pkg::t_cnt       i_count,
    input  logic                 i_mode,
    input  smsr_pkg::t_rec       i_rdata_a,
    input  smsr_pkg::t_rec       i_rdata_b,
    output smsr_pkg::t_merge_rd  o_rd,
    output smsr_pkg::t_merge_wr  o_wr,
    output smsr_pkg::t_merge_stat o_stat
);
    import smsr_pkg::*;

    t_merge_state r_state, n_state;
    t_cnt         r_n, n_n;
    logic [CNT_W:0] r_width, n_width;
    t_cnt         r_lo, n_lo;
    t_cnt         r_mid, n_mid;
    t_cnt         r_hi, n_hi;
    t_cnt         r_a, n_a;
    t_cnt         r_b, n_b;
    t_cnt         r_w, n_w;
    logic         r_bank, n_bank;

    logic [SUM_W-1:0] sum_mid;
    logic [SUM_W-1:0] sum_hi;
    logic [SUM_W-1:0] sum_lo;
    logic [SUM_W-1:0] n_ext;
    t_cnt         w_inc;
    logic         a_live;
    logic         b_live;
    logic         take_a;

    // run bounds and the pick decision
    always_comb begin
        n_ext   = SUM_W'(r_n);
        sum_mid = SUM_W'(r_lo) + SUM_W'(r_width);
        sum_hi  = SUM_W'(r_lo) + SUM_W'({r_width, 1'b0});
        sum_lo  = SUM_W'(r_lo) + SUM_W'({r_width, 1'b0});
        w_inc   = r_w + 1'b1;
        a_live  = (r_a < r_mid);
        b_live  = (r_b < r_hi);
        take_a  = a_live && (!b_live ||
                  (smsr_order_img(i_rdata_a.key, i_mode) <=
                   smsr_order_img(i_rdata_b.key, i_mode)));
    end

    // read addresses follow the run heads
    always_comb begin
        o_rd.bank = r_bank;
        o_rd.a    = r_a[ADDR_W-1:0];
        o_rd.b    = r_b[ADDR_W-1:0];
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_width     = r_width;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_a         = r_a;
        n_b         = r_b;
        n_w         = r_w;
        n_bank      = r_bank;
        o_wr.en     = 1'b0;
        o_wr.bank   = ~r_bank;
        o_wr.addr   = r_w[ADDR_W-1:0];
        o_wr.data   = take_a ? i_rdata_a : i_rdata_b;
        o_stat.done = 1'b0;
        o_stat.bank = r_bank;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_width = (CNT_W+1)'(1);
                    n_lo    = '0;
                    n_bank  = 1'b0;
                    n_state = M_SETUP;
                end
            end
            M_SETUP: begin
                if (SUM_W'(r_width) >= n_ext) begin
                    // whole set is one run
                    o_stat.done = 1'b1;
                    n_state     = M_IDLE;
                end else begin
                    n_mid   = (sum_mid > n_ext) ? r_n : sum_mid[CNT_W-1:0];
                    n_hi    = (sum_hi > n_ext) ? r_n : sum_hi[CNT_W-1:0];
                    n_a     = r_lo;
                    n_b     = (sum_mid > n_ext) ? r_n : sum_mid[CNT_W-1:0];
                    n_w     = r_lo;
                    n_state = M_READ;
                end
            end
            M_READ: begin
                n_state = M_PICK;
            end
            M_PICK: begin
                o_wr.en = 1'b1;
                if (take_a) begin
                    n_a = r_a + 1'b1;
                end else begin
                    n_b = r_b + 1'b1;
                end
                n_w = w_inc;
                if (w_inc == r_hi) begin
                    if (sum_lo >= n_ext) begin
                        // pass finished, swap banks
                        n_lo    = '0;
                        n_width = {r_width[CNT_W-1:0], 1'b0};
                        n_bank  = ~r_bank;
                    end else begin
                        n_lo = sum_lo[CNT_W-1:0];
                    end
                    n_state = M_SETUP;
                end else begin
                    n_state = M_READ;
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
        end
    end

    // run pointers
    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_a     <= n_a;
        r_b     <= n_b;
        r_w     <= n_w;
    end

endmodule

@@ hw/rtl/stable_merge_sort_records.sv @@
// top level: record load, sort control, result emission and config register
// load: one beat per cycle into bank 0 while loading, up to 64 records per set
// sort: ceil(log2 n) passes; each record takes a read state, then a pick state,
//   set by the single write port of each bank and the registered read ports
// emit: per result beat, a memory read, then the output register; held while output stalls
// reset: control, record count and compare_mode cleared; record banks undefined
module stable_merge_sort_records (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [smsr_pkg::KEY_PORT_W-1:0]       i_key,
    input  logic [smsr_pkg::TAG_W-1:0]            i_record_tag,
    input  logic                                  i_last_record,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [smsr_pkg::KEY_PORT_W-1:0]       o_sorted_key,
    output logic [smsr_pkg::TAG_W-1:0]            o_sorted_tag,
    output logic                                  o_last_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [smsr_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import smsr_pkg::*;

    t_top_state  r_state, n_state;
    t_cnt        r_count, n_count;
    t_cnt        r_idx, n_idx;
    logic        r_emit_bank, n_emit_bank;
    logic        r_mode;
    logic        r_out_valid;
    logic [KEY_BITS-1:0] r_out_key;
    logic [TAG_W-1:0]    r_out_tag;
    logic        r_out_last;

    logic        in_accept;
    logic        store_ok;
    t_cnt        load_cnt;
    logic        emit_last;
    logic        out_load;
    logic        cfg_write;

    t_merge_rd   merge_rd;
    t_merge_wr   merge_wr;
    t_merge_stat merge_stat;
    t_rec        merge_rdata_a;
    t_rec        merge_rdata_b;
    t_rec        emit_rdata;
    t_rec        load_rec;

    logic        b0_we;
    t_addr       b0_waddr;
    t_rec        b0_wdata;
    logic        b1_we;
    t_addr       raddr_a;
    t_addr       raddr_b;
    t_rec        b0_rdata_a;
    t_rec        b0_rdata_b;
    t_rec        b1_rdata_a;
    t_rec        b1_rdata_b;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SIGNED;
        end else if (cfg_write && (paddr[2] == REG_COMPARE_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_COMPARE_MODE) begin
            prdata = 32'(r_mode);
        end
    end

    // input beat handling
    assign o_in_ready = (r_state == S_LOAD);
    assign in_accept  = i_in_valid && o_in_ready;
    assign store_ok   = (r_count < CNT_W'(MAX_RECORDS));
    assign load_cnt   = store_ok ? (r_count + 1'b1) : r_count;
    assign emit_last  = (CNT_W'(r_idx + 1'b1) == r_count);
    assign load_rec.key = i_key[KEY_BITS-1:0];
    assign load_rec.tag = i_record_tag;

    // top state machine
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_emit_bank = r_emit_bank;
        out_load    = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (in_accept) begin
                    n_count = load_cnt;
                    if (i_last_record) begin
                        n_state = S_SORT;
                    end
                end
            end
            S_SORT: begin
                if (merge_stat.done) begin
                    n_emit_bank = merge_stat.bank;
                    n_idx       = '0;
                    n_state     = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_EMIT_WR;
                end
            end
            S_EMIT_WR: begin
                out_load = 1'b1;
                n_idx    = r_idx + 1'b1;
                if (emit_last) begin
                    n_count = '0;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_idx       <= '0;
            r_emit_bank <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_emit_bank <= n_emit_bank;
        end
    end

    // bank port steering; load and merge never touch the same bank at once
    always_comb begin
        raddr_a  = (r_state == S_SORT) ? merge_rd.a : r_idx[ADDR_W-1:0];
        raddr_b  = merge_rd.b;
        b0_we    = 1'b0;
        b0_waddr = merge_wr.addr;
        b0_wdata = merge_wr.data;
        if (in_accept && store_ok) begin
            b0_we    = 1'b1;
            b0_waddr = r_count[ADDR_W-1:0];
            b0_wdata = load_rec;
        end else if (merge_wr.en && (merge_wr.bank == 1'b0)) begin
            b0_we = 1'b1;
        end
        b1_we         = merge_wr.en && (merge_wr.bank == 1'b1);
        merge_rdata_a = merge_rd.bank ? b1_rdata_a : b0_rdata_a;
        merge_rdata_b = merge_rd.bank ? b1_rdata_b : b0_rdata_b;
        emit_rdata    = r_emit_bank ? b1_rdata_a : b0_rdata_a;
    end

    smsr_ram #(
        .DATA_W ($bits(t_rec)),
        .DEPTH  (MAX_RECORDS)
    ) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (b0_we),
        .i_waddr   (b0_waddr),
        .i_wdata   (b0_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (b0_rdata_a),
        .o_rdata_b (b0_rdata_b)
    );

    smsr_ram #(
        .DATA_W ($bits(t_rec)),
        .DEPTH  (MAX_RECORDS)
    ) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (b1_we),
        .i_waddr   (merge_wr.addr),
        .i_wdata   (merge_wr.data),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (b1_rdata_a),
        .o_rdata_b (b1_rdata_b)
    );

    // merge sequencer
    smsr_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_accept && i_last_record),
        .i_count   (load_cnt),
        .i_mode    (r_mode),
        .i_rdata_a (merge_rdata_a),
        .i_rdata_b (merge_rdata_b),
        .o_rd      (merge_rd),
        .o_wr      (merge_wr),
        .o_stat    (merge_stat)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_key  <= emit_rdata.key;
            r_out_tag  <= emit_rdata.tag;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sorted_key = KEY_PORT_W'(r_out_key);
    assign o_sorted_tag = r_out_tag;
    assign o_last_out   = r_out_last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond store depth");

    a_merge_wr_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        merge_wr.en |-> (r_state == S_SORT))
        else $error("merge write outside sort phase");

    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_last_record) |=> (r_state == S_SORT))
        else $error("closing beat did not start the sort");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT_WR) && emit_last) |=>
        ((r_state == S_LOAD) && (r_count == '0) && o_out_valid && o_last_out))
        else $error("set did not close after final result beat");

endmodule

@@ tb/tb.sv @@
// testbench for stable_merge_sort_records: directed table, random sets, sorted-order check
module tb;
    import smsr_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 8;
    localparam int OVERFLOW_SET  = MAX_RECORDS + 2;
    localparam int SHOWN_FAULTS  = 10;

    // byte addresses of the register map
    localparam logic [APB_ADDR_W-1:0] MODE_ADDR       = {REG_COMPARE_MODE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

    typedef enum logic [1:0] {
        ROW_REC,
        ROW_SOLO,
        ROW_CFG
    } t_row_kind;

    typedef enum logic [1:0] {
        KEYS_TIED,
        KEYS_WIDE,
        KEYS_EDGES,
        KEYS_TEXT
    } t_key_style;

    typedef struct packed {
        t_row_kind             kind;
        logic [63:0]           key;
        logic [TAG_W-1:0]      tag;
        logic                  last;
        logic [63:0]           want_key;
        logic [TAG_W-1:0]      want_tag;
        logic [APB_ADDR_W-1:0] reg_addr;
        logic [31:0]           reg_data;
    } t_stim_row;

    typedef struct packed {
        logic [KEY_PORT_W-1:0] key;
        logic [TAG_W-1:0]      tag;
        logic                  last;
    } t_beat;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [KEY_PORT_W-1:0] i_key         = '0;
    logic [TAG_W-1:0]      i_record_tag  = '0;
    logic                  i_last_record = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [KEY_PORT_W-1:0] o_sorted_key;
    logic [TAG_W-1:0]      o_sorted_tag;
    logic                  o_last_out;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state and the sorted beats still owed by the block
    logic [KEY_BITS-1:0] held_keys[$];
    logic [TAG_W-1:0]    held_tags[$];
    logic                mode_copy = MODE_SIGNED;
    t_beat               due_beats[$];

    int  faults = 0;
    bit  calm = 1'b0;
    bit  long_hold_req = 1'b0;
    t_stim_row dir_rows[$];

    stable_merge_sort_records dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_key         (i_key),
        .i_record_tag  (i_record_tag),
        .i_last_record (i_last_record),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sorted_key  (o_sorted_key),
        .o_sorted_tag  (o_sorted_tag),
        .o_last_out    (o_last_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(2 * CLK_HALF * 2000000);
        $display("tb: errors");
        $finish;
    end

    task automatic log_fault(input string msg);
        faults++;
        if (faults <= SHOWN_FAULTS) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // key rank under the current order: flip the sign bit for signed keys
    function automatic logic [KEY_BITS-1:0] key_rank(input logic [KEY_BITS-1:0] k);
        return {k[KEY_BITS-1] ^ (mode_copy == MODE_SIGNED), k[KEY_BITS-2:0]};
    endfunction

    // stable insertion sort of the held set, queued as the expected beats
    task automatic sort_held_set();
        logic [KEY_BITS-1:0] ks[$];
        logic [TAG_W-1:0]    ts[$];
        logic [KEY_BITS-1:0] k;
        logic [TAG_W-1:0]    t;
        int                  j;
        t_beat               b;
        ks = held_keys;
        ts = held_tags;
        for (int i = 1; i < ks.size(); i++) begin
            k = ks[i];
            t = ts[i];
            j = i - 1;
            // strict compare keeps earlier arrivals first among equal keys
            while (j >= 0 && key_rank(ks[j]) > key_rank(k)) begin
                ks[j + 1] = ks[j];
                ts[j + 1] = ts[j];
                j--;
            end
            ks[j + 1] = k;
            ts[j + 1] = t;
        end
        for (int i = 0; i < ks.size(); i++) begin
            b.key  = ks[i];
            b.tag  = ts[i];
            b.last = (i == ks.size() - 1);
            due_beats.push_back(b);
        end
        held_keys.delete();
        held_tags.delete();
    endtask

    // one accepted record: store it unless full, sort on the last one
    task automatic take_record(input logic [63:0] k, input logic [TAG_W-1:0] t,
                               input logic l);
        if (held_keys.size() < MAX_RECORDS) begin
            held_keys.push_back(k[KEY_BITS-1:0]);
            held_tags.push_back(t);
        end
        if (l) begin
            sort_held_set();
        end
    endtask

    // offer one beat and hold it until accepted
    task automatic offer_record(input logic [63:0] k, input logic [TAG_W-1:0] t,
                                input logic l, input bit predicted);
        i_in_valid    <= 1'b1;
        i_key         <= k;
        i_record_tag  <= t;
        i_last_record <= l;
        do @(posedge i_clk); while (!o_in_ready);
        if (predicted) begin
            take_record(k, t, l);
        end
    endtask

    // sender gap in a random burst
    task automatic maybe_pause();
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 11);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait until the block has emitted everything owed and gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, then read back the mode register
    task automatic program_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[APB_ADDR_W-1:2] == REG_COMPARE_MODE) begin
            mode_copy = data[0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= MODE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {31'b0, mode_copy}) begin
            log_fault($sformatf("compare_mode read: want %0h got %0h", mode_copy, got));
        end
    endtask

    // random key drawn in one of several styles
    function automatic logic [63:0] pick_key(input t_key_style style,
                                             input logic [63:0] tie_a,
                                             input logic [63:0] tie_b);
        logic [63:0] k;
        int          len;
        k = '0;
        case (style)
            KEYS_TIED: begin
                k = $urandom_range(0, 1) ? tie_a : tie_b;
            end
            KEYS_EDGES: begin
                case ($urandom_range(0, 4))
                    0:       k = '0;
                    1:       k = '1;
                    2:       k = {1'b1, 63'b0};
                    3:       k = {1'b0, {63{1'b1}}};
                    default: k = 64'd1;
                endcase
            end
            KEYS_TEXT: begin
                // big-endian bytes from a tiny alphabet, NUL padded
                len = $urandom_range(0, 8);
                for (int b = 0; b < len; b++) begin
                    k[63 - 8 * b -: 8] = 8'h61 + 8'($urandom_range(0, 3));
                end
            end
            default: begin
                k = {$urandom(), $urandom()};
            end
        endcase
        return k;
    endfunction

    // one whole set of n records with the last flag on the final one
    task automatic send_set(input int n);
        t_key_style  style;
        logic [63:0] tie_a;
        logic [63:0] tie_b;
        style = t_key_style'($urandom_range(0, 3));
        tie_a = {$urandom(), $urandom()};
        tie_b = $urandom_range(0, 1) ? {$urandom(), $urandom()} : ~tie_a;
        for (int i = 0; i < n; i++) begin
            maybe_pause();
            offer_record(pick_key(style, tie_a, tie_b), TAG_W'($urandom_range(0, 63)),
                         i == n - 1, 1'b1);
        end
    endtask

    function automatic t_stim_row rec(input logic [63:0] k, input logic [TAG_W-1:0] t,
                                      input logic l);
        t_stim_row r;
        r = '0;
        r.kind = ROW_REC;
        r.key  = k;
        r.tag  = t;
        r.last = l;
        return r;
    endfunction

    function automatic t_stim_row solo(input logic [63:0] k, input logic [TAG_W-1:0] t,
                                       input logic [63:0] wk, input logic [TAG_W-1:0] wt);
        t_stim_row r;
        r = '0;
        r.kind     = ROW_SOLO;
        r.key      = k;
        r.tag      = t;
        r.last     = 1'b1;
        r.want_key = wk;
        r.want_tag = wt;
        return r;
    endfunction

    function automatic t_stim_row cfg(input logic [APB_ADDR_W-1:0] a, input logic [31:0] d);
        t_stim_row r;
        r = '0;
        r.kind     = ROW_CFG;
        r.reg_addr = a;
        r.reg_data = d;
        return r;
    endfunction

    // receiver: random hold-off bursts, one long hold on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (hold_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(1, 11);
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // output check against the oldest owed beat
    initial begin
        t_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (due_beats.size() == 0) begin
                    log_fault($sformatf("unexpected beat key %h tag %0d last %0b",
                                        o_sorted_key, o_sorted_tag, o_last_out));
                end else begin
                    want = due_beats.pop_front();
                    if (o_sorted_key !== want.key) begin
                        log_fault($sformatf("sorted_key want %h got %h", want.key,
                                            o_sorted_key));
                    end
                    if (o_sorted_tag !== want.tag) begin
                        log_fault($sformatf("sorted_tag want %0d got %0d", want.tag,
                                            o_sorted_tag));
                    end
                    if (o_last_out !== want.last) begin
                        log_fault($sformatf("last_out want %0b got %0b", want.last,
                                            o_last_out));
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        t_beat want;
        int    sent;
        int    waited;
        int    n;

        // signed order after reset: extremes, negatives, equal keys
        dir_rows.push_back(solo({1'b1, 63'b0}, 6'd0, {1'b1, 63'b0}, 6'd0));
        dir_rows.push_back(rec({1'b0, {63{1'b1}}}, 6'd1, 1'b0));
        dir_rows.push_back(rec({1'b1, 63'b0}, 6'd2, 1'b0));
        dir_rows.push_back(rec(64'd0, 6'd3, 1'b0));
        dir_rows.push_back(rec('1, 6'd4, 1'b0));
        dir_rows.push_back(rec({1'b0, {63{1'b1}}}, 6'd5, 1'b0));
        dir_rows.push_back(rec(64'd1, 6'd6, 1'b1));
        dir_rows.push_back(solo('1, 6'd63, '1, 6'd63));
        dir_rows.push_back(rec(64'd5, 6'd40, 1'b0));
        dir_rows.push_back(rec(64'd5, 6'd41, 1'b0));
        dir_rows.push_back(rec(64'd5, 6'd42, 1'b1));
        // unsigned order on packed strings
        dir_rows.push_back(cfg(MODE_ADDR, {31'b0, MODE_UNSIGNED}));
        dir_rows.push_back(rec(64'h6162_6400_0000_0000, 6'd10, 1'b0));
        dir_rows.push_back(rec(64'h6162_0000_0000_0000, 6'd11, 1'b0));
        dir_rows.push_back(rec(64'h6162_6300_0000_0000, 6'd12, 1'b0));
        dir_rows.push_back(rec(64'h6162_0000_0000_0000, 6'd13, 1'b0));
        dir_rows.push_back(rec('1, 6'd14, 1'b0));
        dir_rows.push_back(rec(64'd0, 6'd15, 1'b1));
        // a write past the only register must leave unsigned order in place
        dir_rows.push_back(cfg(UNUSED_REG_ADDR, {31'b0, MODE_SIGNED}));
        dir_rows.push_back(rec({1'b1, 63'b0}, 6'd20, 1'b0));
        dir_rows.push_back(rec(64'd1, 6'd21, 1'b1));
        dir_rows.push_back(solo(64'd0, 6'd42, 64'd0, 6'd42));
        dir_rows.push_back(cfg(MODE_ADDR, {31'b0, MODE_SIGNED}));

        // hold reset, then release
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_CFG: begin
                    settle();
                    program_reg(dir_rows[i].reg_addr, dir_rows[i].reg_data);
                end
                ROW_SOLO: begin
                    want.key  = dir_rows[i].want_key;
                    want.tag  = dir_rows[i].want_tag;
                    want.last = 1'b1;
                    due_beats.push_back(want);
                    maybe_pause();
                    offer_record(dir_rows[i].key, dir_rows[i].tag, 1'b1, 1'b0);
                end
                default: begin
                    maybe_pause();
                    offer_record(dir_rows[i].key, dir_rows[i].tag, dir_rows[i].last, 1'b1);
                end
            endcase
        end

        // random phases, alternating order; junk in the upper write bits
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            program_reg(MODE_ADDR, {31'($urandom()), ph[0] ? MODE_SIGNED : MODE_UNSIGNED});
            calm = (ph == 3);
            if (ph == 1) begin
                long_hold_req = 1'b1;
            end
            sent = 0;
            if (ph == 2) begin
                // store full: the records past the limit are dropped, last still sorts
                send_set(OVERFLOW_SET);
                sent = OVERFLOW_SET;
            end
            while (sent < PHASE_ITEMS) begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
                send_set(n);
                sent += n;
            end
        end

        // drain
        i_in_valid <= 1'b0;
        waited = 0;
        while (due_beats.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (due_beats.size() != 0) begin
            log_fault($sformatf("%0d sorted beats never arrived", due_beats.size()));
        end
        if (faults == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ stable_merge_sort_records.f @@
hw/rtl/smsr_pkg.sv
hw/rtl/smsr_ram.sv
hw/rtl/smsr_merge.sv
hw/rtl/stable_merge_sort_records.sv
tb/tb.sv
